### sv/gde_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the group ducking envelope.
// Used by the interfaces, the step divider and the top level; depends on nothing.
package gde_pkg;

	// Level and field widths.
	localparam int LVL_W = 17;
	localparam int SRC_W = 5;
	localparam int TGT_W = 15;
	localparam int SEC_W = 24;
	localparam int FRM_W = 13;

	// Full volume in unsigned 1.16 form.
	localparam logic [LVL_W-1:0] UNITY = 17'h10000;

	// Frame rate used to turn seconds into ticks.
	localparam int FRAMES_PER_SEC = 30;

	// Request operation codes.
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_LOAD = 1'b1;

	// One ducker slot as it lies in the slot memory.
	typedef struct packed {
		logic [SRC_W-1:0] source;
		logic [TGT_W-1:0] targets;
		logic [LVL_W-1:0] full;
		logic [LVL_W-1:0] att_step;
		logic [LVL_W-1:0] rel_step;
		logic [LVL_W-1:0] cur;
	} slot_t;

endpackage

### sv/gde_req_if.sv
`timescale 1ns / 1ps
// Request channel of the group ducking envelope: ticks and ducker loads.
// Depends on gde_pkg for the field widths.
interface gde_req_if;
	logic                         valid;
	logic                         ready;
	logic                         op;
	logic [31:0]                  play_mask;
	logic [1:0]                   ducker_index;
	logic                         ducker_enable;
	logic [gde_pkg::SRC_W-1:0]    trigger_group;
	logic [gde_pkg::TGT_W-1:0]    duck_mask;
	logic [gde_pkg::LVL_W-1:0]    full_duck_level;
	logic [gde_pkg::SEC_W-1:0]    attack_seconds;
	logic [gde_pkg::SEC_W-1:0]    release_seconds;

	modport source (
		output valid, op, play_mask, ducker_index, ducker_enable, trigger_group,
		output duck_mask, full_duck_level, attack_seconds, release_seconds,
		input  ready
	);

	modport sink (
		input  valid, op, play_mask, ducker_index, ducker_enable, trigger_group,
		input  duck_mask, full_duck_level, attack_seconds, release_seconds,
		output ready
	);
endinterface

### sv/gde_rsp_if.sv
`timescale 1ns / 1ps
// Result channel of the group ducking envelope: one changed group per result.
// Depends on gde_pkg for the level width.
interface gde_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [3:0]                   group_index;
	logic [gde_pkg::LVL_W-1:0]    group_level;
	logic                         last;

	modport source (
		output valid, group_index, group_level, last,
		input  ready
	);

	modport sink (
		input  valid, group_index, group_level, last,
		output ready
	);
endinterface

### sv/group_ducking_envelope.sv
`timescale 1ns / 1ps
// Group ducking envelope: duckers ramp group multipliers down and back up.
// A tick reads every slot, then every group, and stalls while the result port is busy;
// that walk is set by the single read port of the slot and group memories.
// A ducker load runs two 17-step divisions on one shared divider.
// Reset clears the slot and group valid bits, so every multiplier reads as full volume.
module group_ducking_envelope #(
	parameter int NUM_DUCKERS = 4,
	parameter int NUM_GROUPS  = 15
) (
	input  logic    clk,
	input  logic    arst_n,
	gde_req_if.sink   req,
	gde_rsp_if.source rsp
);

	localparam int SW = (NUM_DUCKERS > 1) ? $clog2(NUM_DUCKERS) : 1;
	localparam int GW = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
	localparam int AW = (NUM_GROUPS > gde_pkg::TGT_W) ? NUM_GROUPS : gde_pkg::TGT_W;
	localparam int LW = gde_pkg::LVL_W;

	// Sequencer states.
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DIV_A  = 4'd1;
	localparam logic [3:0] S_WAIT_A = 4'd2;
	localparam logic [3:0] S_DIV_R  = 4'd3;
	localparam logic [3:0] S_WAIT_R = 4'd4;
	localparam logic [3:0] S_SRD    = 4'd5;
	localparam logic [3:0] S_SUPD   = 4'd6;
	localparam logic [3:0] S_GRD    = 4'd7;
	localparam logic [3:0] S_GCMP   = 4'd8;
	localparam logic [3:0] S_FLUSH  = 4'd9;

	// Seconds in 8.16 to whole frames, at least one.
	function automatic logic [gde_pkg::FRM_W-1:0] frames_of(
		input logic [gde_pkg::SEC_W-1:0] sec
	);
		logic [gde_pkg::SEC_W+4:0] prod;
		logic [gde_pkg::FRM_W-1:0] frm;
		prod = {sec, 5'b00000} - {4'b0000, sec, 1'b0};
		frm  = prod[gde_pkg::SEC_W+4:16];
		return (frm == '0) ? gde_pkg::FRM_W'(1) : frm;
	endfunction

	logic [3:0]                state_q;
	logic [31:0]               playing_q;
	logic [SW-1:0]             sidx_q;
	logic [GW-1:0]             gidx_q;
	logic [NUM_DUCKERS-1:0]    slot_valid_q;
	logic [NUM_GROUPS-1:0]     grp_valid_q;
	logic [LW-1:0]             track_q [NUM_GROUPS];

	// Load request held during the step divisions.
	logic [SW-1:0]                  cfg_slot_q;
	logic [gde_pkg::SRC_W-1:0]      cfg_src_q;
	logic [gde_pkg::TGT_W-1:0]      cfg_tgt_q;
	logic [LW-1:0]                  cfg_full_q;
	logic [LW-1:0]                  delta_q;
	logic [gde_pkg::SEC_W-1:0]      att_sec_q;
	logic [gde_pkg::SEC_W-1:0]      rel_sec_q;
	logic [LW-1:0]                  att_step_q;

	// Memories and their registered read data.
	gde_pkg::slot_t         slot_mem [NUM_DUCKERS];
	gde_pkg::slot_t         slot_rd_s1;
	logic [LW-1:0]          grp_mem [NUM_GROUPS];
	logic [LW-1:0]          grp_rd_s1;

	// Pending change and output register.
	logic                   pend_v_q;
	logic [GW-1:0]          pend_idx_q;
	logic [LW-1:0]          pend_lvl_q;
	logic                   out_v_q;
	logic [3:0]             out_idx_q;
	logic [LW-1:0]          out_lvl_q;
	logic                   out_last_q;

	logic                   req_fire;
	logic                   slot_ok;
	logic [LW-1:0]          full_sat;
	logic                   div_start;
	logic                   div_done;
	logic [LW-1:0]          div_q;
	logic [LW-1:0]          div_step;
	logic [gde_pkg::FRM_W-1:0] div_dsr;

	logic                   sv_now;
	logic                   play_now;
	logic [LW:0]            dn_lvl;
	logic [LW:0]            up_lvl;
	logic [LW-1:0]          nxt_lvl;
	logic                   aff_now;
	logic [AW-1:0]          aff_wide;

	logic                   slot_we;
	logic [SW-1:0]          slot_wa;
	gde_pkg::slot_t         slot_wd;

	logic [LW-1:0]          old_lvl;
	logic [LW-1:0]          trk_lvl;
	logic                   grp_chg;
	logic                   out_free;
	logic                   gstall;
	logic                   push_mid;
	logic                   push_last;

	assign req.ready = (state_q == S_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign slot_ok   = 32'(req.ducker_index) < NUM_DUCKERS;
	assign full_sat  = (req.full_duck_level > gde_pkg::UNITY) ? gde_pkg::UNITY
	                                                        : req.full_duck_level;

	// Shared step divider: delta over frames for attack, then for release.
	assign div_start = (state_q == S_DIV_A) || (state_q == S_DIV_R);
	assign div_dsr   = frames_of((state_q == S_DIV_A) ? att_sec_q : rel_sec_q);
	assign div_step  = (div_q == '0) ? LW'(1) : div_q;

	gde_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (delta_q),
		.divisor  (div_dsr),
		.done     (div_done),
		.quotient (div_q)
	);

	// Ramp of the slot just read from memory.
	always_comb begin
		sv_now   = slot_valid_q[sidx_q];
		play_now = playing_q[slot_rd_s1.source];
		dn_lvl   = {1'b0, slot_rd_s1.cur} - {1'b0, slot_rd_s1.att_step};
		up_lvl   = {1'b0, slot_rd_s1.cur} + {1'b0, slot_rd_s1.rel_step};
		nxt_lvl  = slot_rd_s1.cur;
		aff_now  = 1'b0;
		if (play_now) begin
			aff_now = 1'b1;
			if (slot_rd_s1.cur != slot_rd_s1.full) begin
				if ($signed(dn_lvl) < $signed({1'b0, slot_rd_s1.full})) begin
					nxt_lvl = slot_rd_s1.full;
				end else begin
					nxt_lvl = dn_lvl[LW-1:0];
				end
			end
		end else if (slot_rd_s1.cur != gde_pkg::UNITY) begin
			aff_now = 1'b1;
			if (up_lvl > {1'b0, gde_pkg::UNITY}) begin
				nxt_lvl = gde_pkg::UNITY;
			end else begin
				nxt_lvl = up_lvl[LW-1:0];
			end
		end
		aff_now  = aff_now && sv_now;
		aff_wide = AW'(slot_rd_s1.targets);
	end

	// Slot memory write port: a finished load or a ramp write-back.
	always_comb begin
		slot_we = ((state_q == S_WAIT_R) && div_done) || ((state_q == S_SUPD) && sv_now);
		slot_wa = (state_q == S_SUPD) ? sidx_q : cfg_slot_q;
		if (state_q == S_SUPD) begin
			slot_wd     = slot_rd_s1;
			slot_wd.cur = nxt_lvl;
		end else begin
			slot_wd.source   = cfg_src_q;
			slot_wd.targets  = cfg_tgt_q;
			slot_wd.full     = cfg_full_q;
			slot_wd.att_step = att_step_q;
			slot_wd.rel_step = div_step;
			slot_wd.cur      = gde_pkg::UNITY;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_we) begin
			slot_mem[slot_wa] <= slot_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_SRD) begin
			slot_rd_s1 <= slot_mem[sidx_q];
		end
	end

	// Group compare: stored multiplier against this tick's minimum.
	always_comb begin
		old_lvl   = grp_valid_q[gidx_q] ? grp_rd_s1 : gde_pkg::UNITY;
		trk_lvl   = track_q[gidx_q];
		grp_chg   = (state_q == S_GCMP) && (old_lvl != trk_lvl);
		out_free  = !out_v_q || rsp.ready;
		gstall    = grp_chg && pend_v_q && !out_free;
		push_mid  = grp_chg && pend_v_q && out_free;
		push_last = (state_q == S_FLUSH) && pend_v_q && out_free;
	end

	always_ff @(posedge clk) begin
		if (grp_chg && !gstall) begin
			grp_mem[gidx_q] <= trk_lvl;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_GRD) begin
			grp_rd_s1 <= grp_mem[gidx_q];
		end
	end

	// Per-group running minimum over the duckers of this tick.
	always_ff @(posedge clk) begin
		for (int c = 0; c < NUM_GROUPS; c++) begin
			if (req_fire && (req.op == gde_pkg::OP_TICK)) begin
				track_q[c] <= gde_pkg::UNITY;
			end else if ((state_q == S_SUPD) && aff_now && aff_wide[c] &&
			             (nxt_lvl < track_q[c])) begin
				track_q[c] <= nxt_lvl;
			end
		end
	end

	// Request capture, and the attack step once its division is done.
	always_ff @(posedge clk) begin
		if (req_fire) begin
			playing_q  <= req.play_mask;
			cfg_slot_q <= SW'(req.ducker_index);
			cfg_src_q  <= req.trigger_group;
			cfg_tgt_q  <= req.duck_mask;
			cfg_full_q <= full_sat;
			delta_q    <= gde_pkg::UNITY - full_sat;
			att_sec_q  <= req.attack_seconds;
			rel_sec_q  <= req.release_seconds;
		end
		if ((state_q == S_WAIT_A) && div_done) begin
			att_step_q <= div_step;
		end
	end

	// Main sequencer with slot and group valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			sidx_q       <= '0;
			gidx_q       <= '0;
			slot_valid_q <= '0;
			grp_valid_q  <= '0;
		end else begin
			if (grp_chg && !gstall) begin
				grp_valid_q[gidx_q] <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						if (req.op == gde_pkg::OP_TICK) begin
							sidx_q  <= '0;
							state_q <= S_SRD;
						end else if (slot_ok && !req.ducker_enable) begin
							slot_valid_q[SW'(req.ducker_index)] <= 1'b0;
						end else if (slot_ok) begin
							state_q <= S_DIV_A;
						end
					end
				end
				S_DIV_A: begin
					state_q <= S_WAIT_A;
				end
				S_WAIT_A: begin
					if (div_done) begin
						state_q <= S_DIV_R;
					end
				end
				S_DIV_R: begin
					state_q <= S_WAIT_R;
				end
				S_WAIT_R: begin
					if (div_done) begin
						slot_valid_q[cfg_slot_q] <= 1'b1;
						state_q                  <= S_IDLE;
					end
				end
				S_SRD: begin
					state_q <= S_SUPD;
				end
				S_SUPD: begin
					if (sidx_q == SW'(NUM_DUCKERS - 1)) begin
						gidx_q  <= '0;
						state_q <= S_GRD;
					end else begin
						sidx_q  <= sidx_q + 1'b1;
						state_q <= S_SRD;
					end
				end
				S_GRD: begin
					state_q <= S_GCMP;
				end
				S_GCMP: begin
					if (!gstall) begin
						if (gidx_q == GW'(NUM_GROUPS - 1)) begin
							state_q <= S_FLUSH;
						end else begin
							gidx_q  <= gidx_q + 1'b1;
							state_q <= S_GRD;
						end
					end
				end
				S_FLUSH: begin
					if (!pend_v_q || out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Pending change: held back until the next change or the end of the tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
		end else if (grp_chg && !gstall) begin
			pend_v_q <= 1'b1;
		end else if (push_last) begin
			pend_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (grp_chg && !gstall) begin
			pend_idx_q <= gidx_q;
			pend_lvl_q <= trk_lvl;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (push_mid || push_last) begin
			out_v_q <= 1'b1;
		end else if (rsp.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_mid || push_last) begin
			out_idx_q  <= 4'(pend_idx_q);
			out_lvl_q  <= pend_lvl_q;
			out_last_q <= push_last;
		end
	end

	assign rsp.valid       = out_v_q;
	assign rsp.group_index = out_idx_q;
	assign rsp.group_level = out_lvl_q;
	assign rsp.last        = out_last_q;

	// A non-final result always has a further change waiting behind it.
	a_mid_has_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !out_last_q) |-> pend_v_q)
		else $error("non-final result without a pending change");

	// No change of the previous tick is left over when a new request is taken.
	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |-> !pend_v_q)
		else $error("request accepted with a pending change");

	// The divider finishes only while the sequencer waits for it.
	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> ((state_q == S_WAIT_A) || (state_q == S_WAIT_R)))
		else $error("divider finished outside a wait state");

	// A group memory write always comes with its valid bit set next cycle.
	a_grp_valid_set: assert property (@(posedge clk) disable iff (!arst_n)
		(grp_chg && !gstall) |=> grp_valid_q[$past(gidx_q)])
		else $error("group written without its valid bit");

endmodule

### sv/gde_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, for the attack and release steps.
// Depends on gde_pkg for the level and frame-count widths.
module gde_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [gde_pkg::LVL_W-1:0]   dividend,
	input  logic [gde_pkg::FRM_W-1:0]   divisor,
	output logic                        done,
	output logic [gde_pkg::LVL_W-1:0]   quotient
);

	localparam int CNT_W = $clog2(gde_pkg::LVL_W);

	logic                        busy_q;
	logic                        done_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [gde_pkg::FRM_W-1:0]   rem_q;
	logic [gde_pkg::FRM_W-1:0]   dsr_q;
	logic [gde_pkg::LVL_W-1:0]   quo_q;

	logic [gde_pkg::FRM_W:0]     shifted;
	logic [gde_pkg::FRM_W+1:0]   diff;
	logic                        fits;

	// Trial subtraction of the divisor from the shifted partial remainder.
	assign shifted = {rem_q, quo_q[gde_pkg::LVL_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, dsr_q};
	assign fits    = !diff[gde_pkg::FRM_W+1];

	// Control: count the quotient bits and flag the last one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(gde_pkg::LVL_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: the dividend shifts out as the quotient shifts in.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[gde_pkg::FRM_W-1:0] : shifted[gde_pkg::FRM_W-1:0];
			quo_q <= {quo_q[gde_pkg::LVL_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

### tb/tb_group_ducking_envelope.sv
`timescale 1ns / 1ps
// Self-checking testbench for the group ducking envelope: directed and random ticks and
// ducker loads, checked against an in-bench model of every ducker and group multiplier.
// Depends on gde_pkg, gde_req_if, gde_rsp_if and group_ducking_envelope.
module tb_group_ducking_envelope;

	localparam int DUCKERS      = 4;
	localparam int GROUPS       = 15;
	localparam int FULL_VOL     = int'(gde_pkg::UNITY);
	localparam int DRAIN_CYCLES = 100;

	// One request as the bench builds it.
	typedef struct packed {
		logic                      op;
		logic [31:0]               playing;
		logic [1:0]                slot;
		logic                      enable;
		logic [gde_pkg::SRC_W-1:0] source;
		logic [gde_pkg::TGT_W-1:0] targets;
		logic [gde_pkg::LVL_W-1:0] full_level;
		logic [gde_pkg::SEC_W-1:0] att_time;
		logic [gde_pkg::SEC_W-1:0] rel_time;
	} duck_req_t;

	// One changed group multiplier.
	typedef struct packed {
		logic [3:0]                group;
		logic [gde_pkg::LVL_W-1:0] level;
		logic                      last;
	} group_update_t;

	logic clk;
	logic arst_n;

	gde_req_if req_ch ();
	gde_rsp_if rsp_ch ();

	group_ducking_envelope i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Model state of the ducker slots and the group multipliers.
	bit                        duck_on      [DUCKERS];
	logic [gde_pkg::SRC_W-1:0] duck_source  [DUCKERS];
	logic [gde_pkg::TGT_W-1:0] duck_targets [DUCKERS];
	int                        duck_full    [DUCKERS];
	int                        duck_fall    [DUCKERS];
	int                        duck_rise    [DUCKERS];
	int                        duck_level   [DUCKERS];
	int                        group_level  [GROUPS];

	group_update_t pending_levels[$];
	int            mismatches;
	int            max_req_gap;
	int            max_rsp_stall;

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard limit on the run.
	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// Turns an 8.16 time into a per-tick step at the frame rate.
	function automatic int seconds_to_step(input int delta,
			input logic [gde_pkg::SEC_W-1:0] secs);
		longint frames;
		int     step;
		frames = (longint'(gde_pkg::FRAMES_PER_SEC) * longint'(secs)) >>> 16;
		if (frames == 0)
			frames = 1;
		step = int'(longint'(delta) / frames);
		if (step == 0)
			step = 1;
		return step;
	endfunction

	// Applies one accepted request to the model and queues the group changes it causes.
	function automatic void predict_request(input duck_req_t r);
		int                        track[GROUPS];
		int                        lvl;
		int                        last_c;
		logic [gde_pkg::TGT_W-1:0] hit;
		group_update_t             upd;
		if (r.op == gde_pkg::OP_LOAD) begin
			if (!r.enable) begin
				duck_on[r.slot] = 1'b0;
			end else begin
				lvl = (int'(r.full_level) > FULL_VOL) ? FULL_VOL : int'(r.full_level);
				duck_on[r.slot]      = 1'b1;
				duck_source[r.slot]  = r.source;
				duck_targets[r.slot] = r.targets;
				duck_full[r.slot]    = lvl;
				duck_fall[r.slot]    = seconds_to_step(FULL_VOL - lvl, r.att_time);
				duck_rise[r.slot]    = seconds_to_step(FULL_VOL - lvl, r.rel_time);
				duck_level[r.slot]   = FULL_VOL;
			end
			return;
		end
		for (int c = 0; c < GROUPS; c++)
			track[c] = FULL_VOL;
		// Ramp each enabled ducker and fold it into the groups it touches.
		for (int i = 0; i < DUCKERS; i++) begin
			if (!duck_on[i])
				continue;
			lvl = duck_level[i];
			hit = '0;
			if (r.playing[duck_source[i]]) begin
				if (lvl != duck_full[i]) begin
					lvl -= duck_fall[i];
					if (lvl < duck_full[i])
						lvl = duck_full[i];
				end
				hit = duck_targets[i];
			end else if (lvl != FULL_VOL) begin
				lvl += duck_rise[i];
				if (lvl > FULL_VOL || lvl < 0)
					lvl = FULL_VOL;
				hit = duck_targets[i];
			end
			duck_level[i] = lvl;
			for (int c = 0; c < GROUPS; c++)
				if (hit[c] && lvl < track[c])
					track[c] = lvl;
		end
		// Every changed group is reported in ascending order, the final one flagged.
		last_c = -1;
		for (int c = 0; c < GROUPS; c++)
			if (group_level[c] != track[c])
				last_c = c;
		for (int c = 0; c < GROUPS; c++) begin
			if (group_level[c] != track[c]) begin
				group_level[c] = track[c];
				upd.group = 4'(c);
				upd.level = gde_pkg::LVL_W'(track[c]);
				upd.last  = (c == last_c);
				pending_levels.push_back(upd);
			end
		end
	endfunction

	// Sends one request after a random gap and updates the model when it is taken.
	task automatic send_request(input duck_req_t r);
		int gap;
		gap = $urandom_range(0, max_req_gap);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid           <= 1'b1;
		req_ch.op              <= r.op;
		req_ch.play_mask       <= r.playing;
		req_ch.ducker_index    <= r.slot;
		req_ch.ducker_enable   <= r.enable;
		req_ch.trigger_group   <= r.source;
		req_ch.duck_mask       <= r.targets;
		req_ch.full_duck_level <= r.full_level;
		req_ch.attack_seconds  <= r.att_time;
		req_ch.release_seconds <= r.rel_time;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		predict_request(r);
	endtask

	// A request with every field random; callers fix what matters.
	function automatic duck_req_t random_request();
		duck_req_t r;
		r.op         = 1'($urandom);
		r.playing    = $urandom;
		r.slot       = 2'($urandom);
		r.enable     = 1'($urandom);
		r.source     = gde_pkg::SRC_W'($urandom);
		r.targets    = gde_pkg::TGT_W'($urandom);
		r.full_level = gde_pkg::LVL_W'($urandom);
		r.att_time   = gde_pkg::SEC_W'($urandom);
		r.rel_time   = gde_pkg::SEC_W'($urandom);
		return r;
	endfunction

	task automatic send_tick(input logic [31:0] playing);
		duck_req_t r;
		r         = random_request();
		r.op      = gde_pkg::OP_TICK;
		r.playing = playing;
		send_request(r);
	endtask

	task automatic send_load(input int slot, input int src, input int tgt, input int full,
			input int att, input int rel);
		duck_req_t r;
		r            = random_request();
		r.op         = gde_pkg::OP_LOAD;
		r.enable     = 1'b1;
		r.slot       = 2'(slot);
		r.source     = gde_pkg::SRC_W'(src);
		r.targets    = gde_pkg::TGT_W'(tgt);
		r.full_level = gde_pkg::LVL_W'(full);
		r.att_time   = gde_pkg::SEC_W'(att);
		r.rel_time   = gde_pkg::SEC_W'(rel);
		send_request(r);
	endtask

	task automatic send_disable(input int slot);
		duck_req_t r;
		r        = random_request();
		r.op     = gde_pkg::OP_LOAD;
		r.enable = 1'b0;
		r.slot   = 2'(slot);
		send_request(r);
	endtask

	// Ticks with no ducker loaded never change a group; a disable of an empty slot follows.
	task automatic test_idle_ticks();
		send_tick(32'h0000_0000);
		send_tick(32'hFFFF_FFFF);
		send_disable(2);
	endtask

	// Instant attack to silence on every group, slow release, then disable mid-release.
	task automatic test_single_ramp();
		send_load(0, 3, 'h7FFF, 0, 0, 'hFF_FFFF);
		send_tick(32'h0000_0008);
		send_tick(32'h0000_0008);
		send_tick(32'h0000_0000);
		send_tick(32'h0000_0000);
		send_disable(0);
		send_tick(32'h0000_0000);
	endtask

	// Saturated full level, top source group, tiny and huge times, overlapping duckers.
	task automatic test_level_extremes();
		send_load(1, 31, 'h5555, 'h1FFFF, 'h10000, 'h10000);
		send_tick(32'h8000_0000);
		send_load(2, 31, 'h4001, 'h08000, 'h10000, 'h00800);
		send_tick(32'h8000_0000);
		send_tick(32'h8000_0000);
		send_tick(32'h0000_0000);
		send_load(3, 0, 'h0003, 'h0FFFF, 'hFF_FFFF, 0);
		send_tick(32'h0000_0001);
		send_tick(32'h0000_0001);
		send_tick(32'h8000_0001);
		send_tick(32'h0000_0000);
		send_tick(32'h0000_0000);
	endtask

	// Mostly ticks with persistent playing masks so ramps run their course, some loads.
	task automatic test_random_traffic(input int count);
		logic [31:0] held;
		duck_req_t   r;
		held = $urandom;
		for (int k = 0; k < count; k++) begin
			// Rotate idling: both sides, none, sender only, receiver only.
			if (k % 65 == 0) begin
				max_req_gap   = ((k / 65) % 4 == 0 || (k / 65) % 4 == 2) ? 8 : 0;
				max_rsp_stall = ((k / 65) % 4 == 0 || (k / 65) % 4 == 3) ? 8 : 0;
			end
			r = random_request();
			if ($urandom_range(0, 99) < 8) begin
				r.op     = gde_pkg::OP_LOAD;
				r.enable = ($urandom_range(0, 9) != 0);
				if ($urandom_range(0, 3) != 0)
					r.full_level = gde_pkg::LVL_W'($urandom_range(0, FULL_VOL));
				if ($urandom_range(0, 3) != 0) begin
					r.att_time = gde_pkg::SEC_W'($urandom_range(0, 'h30000));
					r.rel_time = gde_pkg::SEC_W'($urandom_range(0, 'h30000));
				end
			end else begin
				r.op = gde_pkg::OP_TICK;
				held ^= $urandom & $urandom & $urandom;
				r.playing = ($urandom_range(0, 9) == 0) ? $urandom : held;
			end
			send_request(r);
		end
	endtask

	// Result side: random stalls per result, and a check of each accepted result.
	initial begin
		int            stall_left;
		group_update_t want;
		rsp_ch.ready <= 1'b0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (pending_levels.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result, group %0d level %h last %0b", $time,
						rsp_ch.group_index, rsp_ch.group_level, rsp_ch.last);
				end else begin
					want = pending_levels.pop_front();
					if (rsp_ch.group_index !== want.group) begin
						mismatches++;
						$display("%0t: group_index expected %0d actual %0d", $time,
							want.group, rsp_ch.group_index);
					end
					if (rsp_ch.group_level !== want.level) begin
						mismatches++;
						$display("%0t: group_level expected %h actual %h", $time,
							want.level, rsp_ch.group_level);
					end
					if (rsp_ch.last !== want.last) begin
						mismatches++;
						$display("%0t: last expected %0b actual %0b", $time,
							want.last, rsp_ch.last);
					end
				end
				stall_left = $urandom_range(0, max_rsp_stall);
			end
			if (stall_left > 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Reset, the tests in turn, drain and verdict.
	initial begin
		arst_n                 <= 1'b0;
		req_ch.valid           <= 1'b0;
		req_ch.op              <= gde_pkg::OP_TICK;
		req_ch.play_mask       <= '0;
		req_ch.ducker_index    <= '0;
		req_ch.ducker_enable   <= 1'b0;
		req_ch.trigger_group   <= '0;
		req_ch.duck_mask       <= '0;
		req_ch.full_duck_level <= '0;
		req_ch.attack_seconds  <= '0;
		req_ch.release_seconds <= '0;
		mismatches    = 0;
		max_req_gap   = 8;
		max_rsp_stall = 8;
		for (int i = 0; i < DUCKERS; i++) begin
			duck_on[i]      = 1'b0;
			duck_source[i]  = '0;
			duck_targets[i] = '0;
			duck_full[i]    = 0;
			duck_fall[i]    = 0;
			duck_rise[i]    = 0;
			duck_level[i]   = FULL_VOL;
		end
		for (int c = 0; c < GROUPS; c++)
			group_level[c] = FULL_VOL;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_ticks();
		test_single_ramp();
		test_level_extremes();
		test_random_traffic(260);
		req_ch.valid <= 1'b0;
		while (pending_levels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
